[hw/rtl/ltci_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ltci_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 9;
    localparam int VAL_W       = 17;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 4;
    localparam int GUESS_W     = VAL_W + 1;
    localparam int MUL_W       = 2 * GUESS_W;

    localparam logic [VAL_W-1:0]   ONE_Q16     = VAL_W'(1) << FRAC_W;
    localparam logic [VAL_W-1:0]   HALF_Q16    = VAL_W'(1) << (FRAC_W - 1);
    localparam logic [GUESS_W-1:0] GUESS_HI    = GUESS_W'(1) << (FRAC_W + 1);
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(256);
    localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(15);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_TOLIN = 2'd2,
        OP_FRLIN = 2'd3
    } op_t;

endpackage
`default_nettype wire

[hw/rtl/ltci_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ltci_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/lut_tone_curve_interp_inverse_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Tone-curve table engine: Q1.16 forward table with an inverse built by bisection.
// Input beat (s_*): s_tuser = operation (0 load, 1 build inverse, 2 to linear,
// 3 from linear); s_tdata = entry_index and sample. Every input beat yields
// exactly one output beat (m_*): m_tdata = result_value, m_tuser = inverse_ready.
// cfg_we/cfg_wdata write table_size (clamped to 2..256); a write clears the
// inverse-valid flag. Write it only while the block is idle.
// Timing: one item at a time; s_tready is high only in the idle state.
// A load goes from the idle state straight to the output state; a conversion
// steps through multiply for the position, two reads of one RAM port, multiply
// for the blend and sum, and needs only one read when the input clamps to the last entry.
// A build runs 16 bisection steps for every entry in use, each step an
// interpolation plus a multiply and compare on the one shared multiplier.
// Reset clears the sequencer, the inverse-valid flag and the output beat and
// sets table_size to 256; table contents are undefined until loaded or built.
// If m_tready is low the finished result waits in the output register and the
// sequencer holds until it can hand the next result over.
module lut_tone_curve_interp_inverse_top
    import ltci_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [7:0] entry_index, [24:8] sample
    input  wire logic [1:0]        s_tuser,   // [1:0] operation
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [23:0]       m_tdata,   // [16:0] result_value
    output logic      [0:0]        m_tuser,   // [0] inverse_ready
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MULP = 9'b000000010,
        ST_ADDR = 9'b000000100,
        ST_RD0  = 9'b000001000,
        ST_RD1  = 9'b000010000,
        ST_ACC  = 9'b000100000,
        ST_MULV = 9'b001000000,
        ST_CMP  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic [VAL_W-1:0]           x_reg, x_next;
    logic [ADDR_W-1:0]          e_reg, e_next;
    logic [FRAC_W-1:0]          f_reg, f_next;
    logic                       last_reg, last_next;
    logic [VAL_W-1:0]           t0_reg, t0_next;
    logic [VAL_W-1:0]           val_reg, val_next;
    logic signed [MUL_W-1:0]    prod_reg, prod_next;
    logic [GUESS_W-1:0]         lo_reg, lo_next, hi_reg, hi_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [ADDR_W-1:0]          j_reg, j_next;
    logic                       inv_valid_reg, inv_valid_next;
    logic [SIZE_W-1:0]          size_reg, size_next;
    logic                       m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]           m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    logic [ADDR_W-1:0]          nm1;
    logic                       accept;
    op_t                        in_op;
    logic [7:0]                 in_idx;
    logic [VAL_W-1:0]           in_sample;
    logic signed [GUESS_W-1:0]  mul_a, mul_b;
    logic signed [MUL_W-1:0]    mul_p;
    logic [ADDR_W:0]            pos_e;
    logic                       pos_last;
    logic [ADDR_W-1:0]          raddr;
    logic [VAL_W-1:0]           rdata, fwd_rdata, inv_rdata;
    logic                       fwd_we, inv_we;
    logic [ADDR_W-1:0]          fwd_waddr;
    logic [VAL_W-1:0]           fwd_wdata;
    logic [MUL_W:0]             blend;
    logic [MUL_W-2:0]           target;
    logic [GUESS_W-1:0]         lo_upd, hi_upd;
    logic [GUESS_W:0]           guess_sum;
    logic [VAL_W-1:0]           guess_x;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_op     = op_t'(s_tuser);
    assign in_idx    = s_tdata[7:0];
    assign in_sample = s_tdata[8 +: VAL_W];
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = 24'(m_data_reg);
    assign m_tuser   = m_user_reg;

    // Effective size minus one, clamped to 1..TABLE_DEPTH-1
    always_comb
    begin
        if (size_reg < SIZE_W'(2))
        begin
            nm1 = ADDR_W'(1);
        end
        else if (32'(size_reg) > TABLE_DEPTH)
        begin
            nm1 = ADDR_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            nm1 = ADDR_W'(size_reg - SIZE_W'(1));
        end
    end

    // Inputs above one can push the segment index past the table
    assign pos_e    = prod_reg[FRAC_W +: ADDR_W + 1];
    assign pos_last = (pos_e >= (ADDR_W + 1)'(nm1));
    assign rdata    = (op_reg == OP_FRLIN) ? inv_rdata : fwd_rdata;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MULP:
            begin
                mul_a = GUESS_W'(x_reg);
                mul_b = GUESS_W'(nm1);
            end
            ST_RD1:
            begin
                mul_a = GUESS_W'(rdata) - GUESS_W'(t0_reg);
                mul_b = GUESS_W'(f_reg);
            end
            ST_MULV:
            begin
                mul_a = GUESS_W'(val_reg);
                mul_b = GUESS_W'(nm1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (state_reg)
            ST_ADDR: raddr = pos_last ? nm1 : pos_e[ADDR_W-1:0];
            ST_RD0:  raddr = e_reg + ADDR_W'(1);
            default: raddr = e_reg;
        endcase
    end

    assign blend  = (MUL_W + 1)'({t0_reg, FRAC_W'(0)})
                  + (MUL_W + 1)'(prod_reg)
                  + (MUL_W + 1)'(HALF_Q16);
    assign target = (MUL_W - 1)'({j_reg, FRAC_W'(0)});

    // Bisection update: move lo up when the curve is below the target, hi down
    // when above, and hold both on an exact hit
    always_comb
    begin
        lo_upd = lo_reg;
        hi_upd = hi_reg;
        if (prod_reg[MUL_W-2:0] < target)
        begin
            lo_upd = guess_sum[GUESS_W:1];
        end
        else if (prod_reg[MUL_W-2:0] > target)
        begin
            hi_upd = guess_sum[GUESS_W:1];
        end
    end

    assign guess_sum = (GUESS_W + 1)'(lo_reg) + (GUESS_W + 1)'(hi_reg);
    assign guess_x   = VAL_W'(((GUESS_W + 1)'(lo_upd) + (GUESS_W + 1)'(hi_upd)) >> 2);

    assign fwd_we    = accept && (in_op == OP_LOAD) && (32'(in_idx) < TABLE_DEPTH);
    assign fwd_waddr = ADDR_W'(in_idx);
    assign fwd_wdata = (in_sample > ONE_Q16) ? ONE_Q16 : in_sample;
    assign inv_we    = (state_reg == ST_CMP) && (step_reg == STEP_LAST);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        last_next      = last_reg;
        t0_next        = t0_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        step_next      = step_reg;
        j_next         = j_reg;
        inv_valid_next = inv_valid_reg;
        size_next      = size_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            size_next      = cfg_wdata;
            inv_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = in_op;
                    x_next  = in_sample;
                    unique case (in_op)
                        OP_LOAD:
                        begin
                            inv_valid_next = 1'b0;
                            val_next       = '0;
                            state_next     = ST_OUT;
                        end
                        OP_BUILD:
                        begin
                            j_next     = '0;
                            step_next  = '0;
                            lo_next    = '0;
                            hi_next    = GUESS_HI;
                            x_next     = VAL_W'(GUESS_HI >> 2);
                            state_next = ST_MULP;
                        end
                        default:
                        begin
                            state_next = ST_MULP;
                        end
                    endcase
                end
            end
            ST_MULP:
            begin
                prod_next  = mul_p;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                last_next  = pos_last;
                e_next     = pos_e[ADDR_W-1:0];
                f_next     = prod_reg[FRAC_W-1:0];
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                if (last_reg)
                begin
                    val_next   = rdata;
                    state_next = (op_reg == OP_BUILD) ? ST_MULV : ST_OUT;
                end
                else
                begin
                    t0_next    = rdata;
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                val_next   = blend[FRAC_W +: VAL_W];
                state_next = (op_reg == OP_BUILD) ? ST_MULV : ST_OUT;
            end
            ST_MULV:
            begin
                prod_next  = mul_p;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (step_reg == STEP_LAST)
                begin
                    // Entry done: restart the bracket for the next one
                    step_next = '0;
                    lo_next   = '0;
                    hi_next   = GUESS_HI;
                    x_next    = VAL_W'(GUESS_HI >> 2);
                    if (j_reg == nm1)
                    begin
                        inv_valid_next = 1'b1;
                        val_next       = '0;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        j_next     = j_reg + ADDR_W'(1);
                        state_next = ST_MULP;
                    end
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    lo_next    = lo_upd;
                    hi_next    = hi_upd;
                    x_next     = guess_x;
                    state_next = ST_MULP;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = val_reg;
                    m_user_next  = inv_valid_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inv_valid_reg <= 1'b0;
            size_reg      <= SIZE_RESET;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inv_valid_reg <= inv_valid_next;
            size_reg      <= size_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        x_reg      <= x_next;
        e_reg      <= e_next;
        f_reg      <= f_next;
        last_reg   <= last_next;
        t0_reg     <= t0_next;
        val_reg    <= val_next;
        prod_reg   <= prod_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        step_reg   <= step_next;
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    ltci_ram #(
        .WIDTH(VAL_W),
        .DEPTH(TABLE_DEPTH)
    ) u_fwd_ram (
        .clk  (clk),
        .we   (fwd_we),
        .waddr(fwd_waddr),
        .wdata(fwd_wdata),
        .raddr(raddr),
        .rdata(fwd_rdata)
    );

    ltci_ram #(
        .WIDTH(VAL_W),
        .DEPTH(TABLE_DEPTH)
    ) u_inv_ram (
        .clk  (clk),
        .we   (inv_we),
        .waddr(j_reg),
        .wdata(guess_x),
        .raddr(raddr),
        .rdata(inv_rdata)
    );

endmodule
`default_nettype wire
